// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the stabilizer modules.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define DPS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define DPS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define DPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/dps_pkg.sv =====
// Package of the detection position stabilizer: constants, register codes and the
// command that passes from the front part to the back part. No dependencies.
package dps_pkg;

	// Default sizes of the target table and of a stored coordinate.
	localparam int DPS_NUM_TARGETS = 10;
	localparam int DPS_POS_WIDTH   = 16;

	// Target number that marks an incomplete detection.
	localparam logic [3:0] INCOMPLETE_NUM = 4'd11;

	// The stability count saturates here.
	localparam logic [2:0] CNT_MAX = 3'd7;

	// Command queue between front and back.
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TRACKING_ENABLE = 3'd0,
		CFG_MATCH_WINDOW    = 3'd1,
		CFG_FAR_COUNT       = 3'd2,
		CFG_NEAR_COUNT      = 3'd3,
		CFG_NEAR_RADIUS     = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic        tracking_enable;
		logic [11:0] match_window;
		logic [2:0]  far_count;
		logic [2:0]  near_count;
		logic [14:0] near_radius;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		tracking_enable: 1'b0,
		match_window:    12'd128,
		far_count:       3'd4,
		near_count:      3'd2,
		near_radius:     15'd1024
	};

	// One classified item: a detection to apply and/or a scan end to apply.
	typedef struct packed {
		logic               detect;
		logic               scan_end;
		logic [3:0]         num;
		logic signed [16:0] sum_x;
		logic signed [16:0] sum_y;
		logic signed [16:0] sum_z;
	} cmd_t;

endpackage

// ===== hdl/dps_ifs.sv =====
// Handshake interfaces of the stabilizer: detection input, published output
// and configuration write. Depends on dps_pkg.
interface dps_det_if import dps_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [3:0]        target_number;
	logic signed [15:0] offset_x;
	logic signed [15:0] offset_y;
	logic signed [15:0] offset_z;
	logic signed [15:0] vehicle_x;
	logic signed [15:0] vehicle_y;
	logic signed [15:0] vehicle_z;
	logic              scan_end;

	modport source(output valid, target_number, offset_x, offset_y, offset_z,
		vehicle_x, vehicle_y, vehicle_z, scan_end, input ready);
	modport sink(input valid, target_number, offset_x, offset_y, offset_z,
		vehicle_x, vehicle_y, vehicle_z, scan_end, output ready);
endinterface

interface dps_pub_if import dps_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [3:0]        published_number;
	logic signed [15:0] published_x;
	logic signed [15:0] published_y;
	logic signed [15:0] published_z;

	modport source(output valid, published_number, published_x, published_y,
		published_z, input ready);
	modport sink(input valid, published_number, published_x, published_y,
		published_z, output ready);
endinterface

interface dps_cfg_if import dps_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== hdl/dps_front.sv =====
// Front part: accepts detection items, tracks the skip-rest-of-scan flag and
// turns each item that changes state into a queue command. Depends on dps_pkg, dps_ifs, assert_macros.svh.
`include "assert_macros.svh"

module dps_front import dps_pkg::*; #(
	parameter int NUM_TARGETS = DPS_NUM_TARGETS
) (
	input  logic       clk,
	input  logic       arst_n,
	dps_det_if.sink    det,
	input  logic       tracking_enable,
	output logic       push_valid,
	input  logic       push_ready,
	output cmd_t       push_cmd
);

	logic skip_q;
	logic acc;
	logic bad_num;
	logic do_detect;

	// An item is taken whenever the queue has room.
	assign det.ready = push_ready;
	assign acc       = det.valid && det.ready;

	// Incomplete or out-of-range numbers end the useful part of the scan.
	assign bad_num   = (det.target_number == INCOMPLETE_NUM) ||
		({1'b0, det.target_number} >= 5'(NUM_TARGETS));
	assign do_detect = !skip_q && !bad_num;

	// Only items that change state reach the back part.
	assign push_valid = acc && tracking_enable && (do_detect || det.scan_end);

	always_comb begin
		push_cmd.detect   = do_detect;
		push_cmd.scan_end = det.scan_end;
		push_cmd.num      = do_detect ? det.target_number : 4'd0;
		push_cmd.sum_x    = 17'(det.offset_x) + 17'(det.vehicle_x);
		push_cmd.sum_y    = 17'(det.offset_y) + 17'(det.vehicle_y);
		push_cmd.sum_z    = 17'(det.offset_z) + 17'(det.vehicle_z);
	end

	// Skip flag: set by a bad number, cleared at scan end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= 1'b0;
		end else if (acc && tracking_enable) begin
			if (det.scan_end) begin
				skip_q <= 1'b0;
			end else if (!skip_q && bad_num) begin
				skip_q <= 1'b1;
			end
		end
	end

	`DPS_ASSERT_NEXT(a_skip_clears, acc && tracking_enable && det.scan_end, !skip_q, "skip flag survived a scan end")

endmodule

// ===== hdl/dps_cmd_queue.sv =====
// Short command queue between the front and back parts of the stabilizer.
// Depends on dps_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dps_cmd_queue import dps_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	cmd_t               entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;
	logic               push;
	logic               pop;

	assign push_ready = (count_q != Q_CNT_W'(Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_cmd    = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	`DPS_ASSERT(a_count_bound, count_q <= Q_CNT_W'(Q_DEPTH), "queue fill count beyond depth")

endmodule

// ===== hdl/dps_back.sv =====
// Back part: holds the per-target tables, checks consistency, picks the
// threshold, publishes stable positions. Depends on dps_pkg, dps_ifs, assert_macros.svh.
`include "assert_macros.svh"

module dps_back import dps_pkg::*; #(
	parameter int NUM_TARGETS = DPS_NUM_TARGETS,
	parameter int POS_WIDTH   = DPS_POS_WIDTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       pop_valid,
	output logic       pop_ready,
	input  cmd_t       pop_cmd,
	dps_pub_if.source  pub
);

	localparam int IW   = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
	localparam int DW   = POS_WIDTH + 1;
	localparam int PW2  = 2 * POS_WIDTH;
	localparam int SQ_W = (PW2 + 1 > 30) ? PW2 + 1 : 30;
	localparam int SW   = (POS_WIDTH > 17) ? POS_WIDTH : 17;
	localparam int XW   = (POS_WIDTH > 16) ? POS_WIDTH : 16;
	localparam logic signed [SW-1:0] POS_HI = SW'((64'sd1 <<< (POS_WIDTH - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] POS_LO = SW'(-(64'sd1 <<< (POS_WIDTH - 1)));
	localparam logic signed [XW-1:0] OUT_HI = XW'(32767);
	localparam logic signed [XW-1:0] OUT_LO = XW'(-32768);

	typedef enum logic [2:0] {
		BK_IDLE   = 3'b001,
		BK_READ   = 3'b010,
		BK_DECIDE = 3'b100
	} bk_state_t;

	// Saturate a 17-bit sum to the stored coordinate width.
	function automatic logic signed [POS_WIDTH-1:0] sat_pos(input logic signed [16:0] v);
		logic signed [SW-1:0] e;
		e = SW'(v);
		if (e > POS_HI) begin
			e = POS_HI;
		end else if (e < POS_LO) begin
			e = POS_LO;
		end
		return e[POS_WIDTH-1:0];
	endfunction

	// Saturate a stored coordinate to the 16-bit output field.
	function automatic logic signed [15:0] sat_out(input logic signed [POS_WIDTH-1:0] v);
		logic signed [XW-1:0] e;
		e = XW'(v);
		if (e > OUT_HI) begin
			e = OUT_HI;
		end else if (e < OUT_LO) begin
			e = OUT_LO;
		end
		return e[15:0];
	endfunction

	bk_state_t state_q;
	bk_state_t state_d;

	// Per-target tables.
	logic signed [POS_WIDTH-1:0] cur_x_q  [NUM_TARGETS];
	logic signed [POS_WIDTH-1:0] cur_y_q  [NUM_TARGETS];
	logic signed [POS_WIDTH-1:0] cur_z_q  [NUM_TARGETS];
	logic signed [POS_WIDTH-1:0] prev_x_q [NUM_TARGETS];
	logic signed [POS_WIDTH-1:0] prev_y_q [NUM_TARGETS];
	logic [2:0]                  count_q  [NUM_TARGETS];

	// Command being worked on.
	logic                        detect_s1;
	logic                        scan_end_s1;
	logic [3:0]                  num_s1;
	logic signed [POS_WIDTH-1:0] p_x_s1;
	logic signed [POS_WIDTH-1:0] p_y_s1;
	logic signed [POS_WIDTH-1:0] p_z_s1;

	// Results of the read step.
	logic                        consistent_s2;
	logic [PW2-1:0]              sq_x_s2;
	logic [PW2-1:0]              sq_y_s2;
	logic [29:0]                 r2_s2;

	logic                        pub_valid_q;
	logic [3:0]                  pub_num_q;
	logic signed [15:0]          pub_x_q;
	logic signed [15:0]          pub_y_q;
	logic signed [15:0]          pub_z_q;

	logic [IW-1:0]               idx;
	logic                        pop_fire;
	logic signed [DW-1:0]        diff_x;
	logic signed [DW-1:0]        diff_y;
	logic [DW-1:0]               abs_x;
	logic [DW-1:0]               abs_y;
	logic signed [PW2-1:0]       sq_x_w;
	logic signed [PW2-1:0]       sq_y_w;
	logic [29:0]                 r2_w;
	logic [SQ_W-1:0]             d2;
	logic                        far;
	logic [2:0]                  thr;
	logic [2:0]                  cnt_cur;
	logic [2:0]                  cnt_next;
	logic                        publish;
	logic                        commit;

	assign idx       = num_s1[IW-1:0];
	assign pop_ready = (state_q == BK_IDLE);
	assign pop_fire  = pop_valid && pop_ready;

	// Read step: distance to the previous scan and the squared radii.
	assign diff_x = DW'(p_x_s1) - DW'(prev_x_q[idx]);
	assign diff_y = DW'(p_y_s1) - DW'(prev_y_q[idx]);
	assign abs_x  = diff_x[DW-1] ? DW'(-diff_x) : DW'(diff_x);
	assign abs_y  = diff_y[DW-1] ? DW'(-diff_y) : DW'(diff_y);
	assign sq_x_w = p_x_s1 * p_x_s1;
	assign sq_y_w = p_y_s1 * p_y_s1;
	assign r2_w   = cfg.near_radius * cfg.near_radius;

	// Decide step: threshold choice, new count and publication.
	assign d2      = SQ_W'(sq_x_s2) + SQ_W'(sq_y_s2);
	assign far     = d2 > SQ_W'(r2_s2);
	assign thr     = far ? cfg.far_count : cfg.near_count;
	assign cnt_cur = count_q[idx];
	assign cnt_next = consistent_s2 ? ((cnt_cur < CNT_MAX) ? cnt_cur + 3'd1 : cnt_cur) : 3'd0;
	assign publish = detect_s1 && (cnt_next >= thr);
	assign commit  = (state_q == BK_DECIDE) && (!pub_valid_q || pub.ready);

	// Sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (pop_fire) begin
					state_d = BK_READ;
				end
			end
			BK_READ: begin
				state_d = BK_DECIDE;
			end
			BK_DECIDE: begin
				if (commit) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Control, tables and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			pub_valid_q <= 1'b0;
			for (int t = 0; t < NUM_TARGETS; t++) begin
				cur_x_q[t]  <= '0;
				cur_y_q[t]  <= '0;
				cur_z_q[t]  <= '0;
				prev_x_q[t] <= '0;
				prev_y_q[t] <= '0;
				count_q[t]  <= '0;
			end
		end else begin
			state_q <= state_d;
			// The result register fills on a publishing commit and empties when taken.
			if (commit && publish) begin
				pub_valid_q <= 1'b1;
			end else if (pub.valid && pub.ready) begin
				pub_valid_q <= 1'b0;
			end
			if (commit) begin
				if (detect_s1) begin
					cur_x_q[idx] <= p_x_s1;
					cur_y_q[idx] <= p_y_s1;
					cur_z_q[idx] <= p_z_s1;
					count_q[idx] <= publish ? 3'd0 : cnt_next;
				end
				// At scan end the previous store takes the updated current store.
				if (scan_end_s1) begin
					for (int t = 0; t < NUM_TARGETS; t++) begin
						if (detect_s1 && (idx == IW'(t))) begin
							prev_x_q[t] <= p_x_s1;
							prev_y_q[t] <= p_y_s1;
						end else begin
							prev_x_q[t] <= cur_x_q[t];
							prev_y_q[t] <= cur_y_q[t];
						end
					end
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (pop_fire) begin
			detect_s1   <= pop_cmd.detect;
			scan_end_s1 <= pop_cmd.scan_end;
			num_s1      <= pop_cmd.num;
			p_x_s1      <= sat_pos(pop_cmd.sum_x);
			p_y_s1      <= sat_pos(pop_cmd.sum_y);
			p_z_s1      <= sat_pos(pop_cmd.sum_z);
		end
		if (state_q == BK_READ) begin
			consistent_s2 <= (abs_x < DW'(cfg.match_window)) &&
				(abs_y < DW'(cfg.match_window));
			sq_x_s2       <= PW2'($unsigned(sq_x_w));
			sq_y_s2       <= PW2'($unsigned(sq_y_w));
			r2_s2         <= r2_w;
		end
		if (commit && publish) begin
			pub_num_q <= num_s1;
			pub_x_q   <= sat_out(p_x_s1);
			pub_y_q   <= sat_out(p_y_s1);
			pub_z_q   <= sat_out(p_z_s1);
		end
	end

	assign pub.valid            = pub_valid_q;
	assign pub.published_number = pub_num_q;
	assign pub.published_x      = pub_x_q;
	assign pub.published_y      = pub_y_q;
	assign pub.published_z      = pub_z_q;

	`DPS_ASSERT_IMPL(a_pub_from_decide, $rose(pub_valid_q), $past(state_q == BK_DECIDE),
		"result raised outside the decide step")
	`DPS_ASSERT_NEXT(a_pop_starts_read, pop_fire, state_q == BK_READ,
		"command taken without a read step")

endmodule

// ===== hdl/detection_position_stabilizer_top.sv =====
// Top level of the detection position stabilizer: configuration registers and
// the front, queue and back parts. Depends on dps_pkg, dps_ifs and the submodules.

// The block takes one detection item per handshake and publishes a target's
// absolute position once it has stayed inside the match window for enough
// scans. The front part takes an item whenever the two-entry command queue
// has room; items seen while tracking is off, and dropped items without a
// scan-end mark, end there. Every other item passes the back part in steps:
// take the command, read the target table and square the coordinates, then
// decide and write back. No new command is taken before the last is written
// back; decide waits while the one-entry result register waits to be taken.
// State comes out of reset cleared at once; there is no clearing pass.
// Configuration writes are always accepted and should be made while idle.
module detection_position_stabilizer_top import dps_pkg::*; #(
	parameter int NUM_TARGETS = DPS_NUM_TARGETS,
	parameter int POS_WIDTH   = DPS_POS_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	dps_cfg_if.sink   cfg,
	dps_det_if.sink   det,
	dps_pub_if.source pub
);

	cfg_t cfg_q;
	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	assign cfg.ready = 1'b1;

	// Configuration registers; writes to unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_TRACKING_ENABLE: cfg_q.tracking_enable <= cfg.data[0];
				CFG_MATCH_WINDOW:    cfg_q.match_window    <= cfg.data[11:0];
				CFG_FAR_COUNT:       cfg_q.far_count       <= cfg.data[2:0];
				CFG_NEAR_COUNT:      cfg_q.near_count      <= cfg.data[2:0];
				CFG_NEAR_RADIUS:     cfg_q.near_radius     <= cfg.data[14:0];
				default: begin
				end
			endcase
		end
	end

	dps_front #(
		.NUM_TARGETS(NUM_TARGETS)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.det             (det),
		.tracking_enable (cfg_q.tracking_enable),
		.push_valid      (push_valid),
		.push_ready      (push_ready),
		.push_cmd        (push_cmd)
	);

	dps_cmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	dps_back #(
		.NUM_TARGETS(NUM_TARGETS),
		.POS_WIDTH  (POS_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.pub       (pub)
	);

endmodule
